/* hdl/assert_macros.svh */
// Assertion macros shared by the stack machine arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define SMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack machine assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SMA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack machine assertion failed");

`else

`define SMA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/sma_pkg.sv */
// Types and constants of the stack machine arithmetic unit.
package sma_pkg;

    // Field widths of the stream channels.
    localparam int OPCODE_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int DATA_W      = 32;
    localparam int DEPTH_OUT_W = 7;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Instruction codes; the remaining codes behave as nop.
    localparam opcode_t OP_NOP  = 3'd0;
    localparam opcode_t OP_PUSH = 3'd1;
    localparam opcode_t OP_ADD  = 3'd2;
    localparam opcode_t OP_SUB  = 3'd3;
    localparam opcode_t OP_MUL  = 3'd4;
    localparam opcode_t OP_DIV  = 3'd5;

    // Status codes reported with every result.
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_SHORT   = 2'd1;
    localparam status_t ST_DIVZERO = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_DIV,
        S_SIGN,
        S_WB
    } state_t;

    // Stack update applied at write-back.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP
    } action_t;

endpackage

/* hdl/stack_machine_alu_core.sv */
// Stack machine arithmetic unit: stack memory, sequencer and iterative divider.
//
// One instruction is taken at a time from the input stream and answered by exactly
// one result transfer describing the stack afterwards. Stack entries live in a
// single-port-write, registered-read memory; the top entry is mirrored in a register,
// so each arithmetic instruction that executes needs one memory read (the second entry)
// and, unless it divides by zero, one write. Up to the result register, nop, push and
// instructions rejected for a short stack pass decode and write-back; add, sub, mul and
// a division by zero pass decode, execute and write-back; div adds the divide state,
// where the radix-2 divider retires one quotient bit per cycle, and the sign state.
// Write-back waits while the output register is full and not being emptied. The next
// instruction is taken in the cycle after the result is loaded, even while that result
// still waits for the downstream side. No clearing pass is needed after reset.
`include "assert_macros.svh"

module stack_machine_alu_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sma_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] push_operand
    input  logic [sma_pkg::OPCODE_W-1:0]  s_tuser,   // [2:0] opcode
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sma_pkg::M_TDATA_W-1:0] m_tdata,   // [1:0] status, [33:2] top_value,
                                                     // [40:34] stack_depth, [47:41] zero
    output logic                          m_tuser    // [0] top_valid
);
    import sma_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DIVC_W = $clog2(DATA_W);

    // Stack storage.
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] rdata_reg;

    // Control state.
    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              m_valid_reg, m_valid_next;

    // Instruction and datapath registers.
    opcode_t           op_reg,      op_next;
    logic [DATA_W-1:0] operand_reg, operand_next;
    action_t           act_reg,     act_next;
    status_t           status_reg,  status_next;
    logic [DATA_W-1:0] res_reg,     res_next;
    logic [DATA_W-1:0] top_reg,     top_next;
    logic [DATA_W-1:0] div_q_reg,   div_q_next;
    logic [DATA_W-1:0] div_r_reg,   div_r_next;
    logic [DATA_W-1:0] div_d_reg,   div_d_next;
    logic [DIVC_W-1:0] div_cnt_reg, div_cnt_next;
    logic              div_neg_reg, div_neg_next;

    // Result register.
    status_t                m_status_reg, m_status_next;
    logic [DATA_W-1:0]      m_top_reg,    m_top_next;
    logic                   m_topv_reg,   m_topv_next;
    logic [DEPTH_OUT_W-1:0] m_depth_reg,  m_depth_next;

    // Helpers.
    logic [CNT_W-1:0]         cnt_m2;
    logic [CNT_W-1:0]         count_after;
    logic [DATA_W-1:0]        top_after;
    logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;
    logic                     wb_go;
    logic                     is_arith;
    logic [DATA_W-1:0]        product;
    logic [DATA_W:0]          rem_shift;
    logic [DATA_W+1:0]        rem_diff;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_topv_reg;
    assign m_tdata  = {{(M_TDATA_W - DEPTH_OUT_W - DATA_W - STATUS_W){1'b0}},
                       m_depth_reg, m_top_reg, m_status_reg};

    assign cnt_m2   = count_reg - CNT_W'(2);
    assign wb_go    = !m_valid_reg || m_tready;
    assign is_arith = (op_reg == OP_ADD) || (op_reg == OP_SUB) ||
                      (op_reg == OP_MUL) || (op_reg == OP_DIV);
    // Only the low word of the product is kept, so a 32 by 32 multiply suffices.
    assign product  = rdata_reg * top_reg;

    // One restoring divider step: shift in the next dividend bit and try the subtract.
    assign rem_shift = {div_r_reg, div_q_reg[DATA_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_d_reg};

    // Stack contents after the pending update.
    always_comb begin
        unique case (act_reg)
            ACT_PUSH: begin
                count_after = count_reg + CNT_W'(1);
                top_after   = operand_reg;
            end
            ACT_POP: begin
                count_after = count_reg - CNT_W'(1);
                top_after   = res_reg;
            end
            default: begin
                count_after = count_reg;
                top_after   = top_reg;
            end
        endcase
    end

    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, count_after};

    // Sequencer: next state, datapath updates and memory accesses.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        operand_next  = operand_reg;
        act_next      = act_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        top_next      = top_reg;
        div_q_next    = div_q_reg;
        div_r_next    = div_r_reg;
        div_d_next    = div_d_reg;
        div_cnt_next  = div_cnt_reg;
        div_neg_next  = div_neg_reg;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_topv_next   = m_topv_reg;
        m_depth_next  = m_depth_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[ADDR_W-1:0];
        mem_wdata     = operand_reg;
        mem_re        = 1'b0;
        mem_raddr     = cnt_m2[ADDR_W-1:0];

        // A taken result frees the output register.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = s_tuser;
                    operand_next = s_tdata;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE: begin
                status_next = ST_OK;
                act_next    = ACT_NONE;
                state_next  = S_WB;
                if (op_reg == OP_PUSH) begin
                    if (count_reg == CNT_W'(STACK_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        act_next = ACT_PUSH;
                    end
                end else if (is_arith) begin
                    if (count_reg < CNT_W'(2)) begin
                        status_next = ST_SHORT;
                    end else begin
                        // Fetch the entry below the top; the top is held in top_reg.
                        mem_re     = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                act_next   = ACT_POP;
                state_next = S_WB;
                unique case (op_reg)
                    OP_ADD: res_next = rdata_reg + top_reg;
                    OP_SUB: res_next = rdata_reg - top_reg;
                    OP_MUL: res_next = product;
                    default: begin
                        if (top_reg == '0) begin
                            status_next = ST_DIVZERO;
                            act_next    = ACT_NONE;
                        end else begin
                            // Divide magnitudes, fix the sign afterwards.
                            div_q_next   = rdata_reg[DATA_W-1] ? (-rdata_reg) : rdata_reg;
                            div_d_next   = top_reg[DATA_W-1] ? (-top_reg) : top_reg;
                            div_r_next   = '0;
                            div_cnt_next = '0;
                            div_neg_next = rdata_reg[DATA_W-1] ^ top_reg[DATA_W-1];
                            state_next   = S_DIV;
                        end
                    end
                endcase
            end

            S_DIV: begin
                if (!rem_diff[DATA_W+1]) begin
                    div_r_next = rem_diff[DATA_W-1:0];
                    div_q_next = {div_q_reg[DATA_W-2:0], 1'b1};
                end else begin
                    div_r_next = rem_shift[DATA_W-1:0];
                    div_q_next = {div_q_reg[DATA_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIVC_W'(1);
                if (div_cnt_reg == DIVC_W'(DATA_W - 1)) begin
                    state_next = S_SIGN;
                end
            end

            S_SIGN: begin
                res_next   = div_neg_reg ? (-div_q_reg) : div_q_reg;
                state_next = S_WB;
            end

            S_WB: begin
                // Commit the stack update together with loading the result register.
                if (wb_go) begin
                    unique case (act_reg)
                        ACT_PUSH: begin
                            mem_we    = 1'b1;
                            mem_waddr = count_reg[ADDR_W-1:0];
                            mem_wdata = operand_reg;
                        end
                        ACT_POP: begin
                            mem_we    = 1'b1;
                            mem_waddr = cnt_m2[ADDR_W-1:0];
                            mem_wdata = res_reg;
                        end
                        default: begin
                            mem_we = 1'b0;
                        end
                    endcase
                    count_next    = count_after;
                    top_next      = top_after;
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_topv_next   = (count_after != '0);
                    m_top_next    = (count_after != '0) ? top_after : '0;
                    m_depth_next  = depth_ext[DEPTH_OUT_W-1:0];
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        operand_reg  <= operand_next;
        act_reg      <= act_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        top_reg      <= top_next;
        div_q_reg    <= div_q_next;
        div_r_reg    <= div_r_next;
        div_d_reg    <= div_d_next;
        div_cnt_reg  <= div_cnt_next;
        div_neg_reg  <= div_neg_next;
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_topv_reg   <= m_topv_next;
        m_depth_reg  <= m_depth_next;
    end

    // Stack memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= stack_mem[mem_raddr];
        end
    end

    // The entry count never runs past the stack size.
    `SMA_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(STACK_DEPTH))
    // A committed push grows the stack by exactly one entry.
    `SMA_ASSERT_NXT(a_push_grows, aclk, aresetn, (state_reg == S_WB) && wb_go && (act_reg == ACT_PUSH), count_reg == $past(count_reg) + CNT_W'(1))
    // Only one instruction is in flight: an input transfer closes the input side.
    `SMA_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A result is loaded only when the output register is free or being emptied.
    `SMA_ASSERT_IMP(a_no_overwrite, aclk, aresetn, (state_reg == S_WB) && m_valid_reg && !m_tready, state_next == S_WB)

endmodule
